>>> rtl/core/plic_pkg.sv
package plic_pkg;

  // Function codes of an input transaction
  localparam logic [1:0] FuncRead  = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;
  localparam logic [1:0] FuncLine  = 2'd2;

  localparam logic [3:0] AccessSize = 4'd4;

  // Address map (byte offsets in the register window)
  localparam logic [25:0] PendBase = 26'h000_1000;
  localparam logic [25:0] EnBaseM  = 26'h000_2000;
  localparam logic [25:0] EnBaseS  = 26'h000_2080;
  localparam logic [25:0] ThrM     = 26'h020_0000;
  localparam logic [25:0] ThrS     = 26'h020_1000;
  localparam logic [25:0] ClmM     = 26'h020_0004;
  localparam logic [25:0] ClmS     = 26'h020_1004;
  localparam logic [25:0] AddrLast = 26'h3FF_FFFC;

  // Context codes
  localparam logic CtxM = 1'b0;
  localparam logic CtxS = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [25:0] addr;
    logic [3:0]  size;
    logic [31:0] wdata;
    logic        line_level;
    logic [9:0]  line_id;
  } req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        fault;
    logic        irq_m;
    logic        irq_s;
  } rsp_t;

  typedef enum logic [3:0] {
    K_NONE,
    K_FAULT,
    K_PRIO_RD,
    K_PRIO_WR,
    K_PEND_RD,
    K_EN_RD,
    K_EN_WR,
    K_THR_RD,
    K_THR_WR,
    K_CLAIM,
    K_COMPLETE,
    K_LINE
  } kind_e;

  // Classified command handed from the front end to the back end
  typedef struct packed {
    kind_e       kind;
    logic        ctx;
    logic [9:0]  idx;
    logic [31:0] wdata;
    logic        level;
  } cmd_t;

endpackage

>>> rtl/core/plic_if.sv
interface plic_req_if;
  import plic_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface plic_rsp_if;
  import plic_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/plic_ram.sv
module plic_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/core/plic_front.sv
module plic_front #(
  parameter int NUM_SOURCES = 63
) (
  plic_req_if.sink        req_i,
  input  logic            full_i,
  output logic            push_o,
  output plic_pkg::cmd_t  cmd_o
);
  import plic_pkg::*;

  localparam int NumWords = (NUM_SOURCES + 32) / 32;
  localparam logic [25:0] PrioEnd = 26'(4 * (NUM_SOURCES + 1));
  localparam logic [25:0] WordSpan = 26'(4 * NumWords);
  localparam logic [25:0] PendEnd = PendBase + WordSpan;
  localparam logic [25:0] EnEndM = EnBaseM + WordSpan;
  localparam logic [25:0] EnEndS = EnBaseS + WordSpan;

  logic        wr;
  logic [25:0] addr;
  logic [25:0] off_p;
  logic [25:0] off_m;
  logic [25:0] off_s;
  logic        cid_ok;
  logic        lid_ok;

  assign req_i.ready = ~full_i;
  assign push_o = req_i.valid & ~full_i;

  assign addr   = req_i.data.addr;
  assign wr     = (req_i.data.func == FuncWrite);
  assign off_p  = addr - PendBase;
  assign off_m  = addr - EnBaseM;
  assign off_s  = addr - EnBaseS;
  assign cid_ok = (req_i.data.wdata != 32'd0) &&
                  (req_i.data.wdata <= 32'(NUM_SOURCES));
  assign lid_ok = (req_i.data.line_id != 10'd0) &&
                  (req_i.data.line_id <= 10'(NUM_SOURCES));

  // address decode and classification
  always_comb begin
    cmd_o.kind  = K_NONE;
    cmd_o.ctx   = CtxM;
    cmd_o.idx   = 10'd0;
    cmd_o.wdata = req_i.data.wdata;
    cmd_o.level = req_i.data.line_level;
    case (req_i.data.func)
      FuncRead, FuncWrite: begin
        if (req_i.data.size != AccessSize || addr > AddrLast) begin
          cmd_o.kind = K_FAULT;
        end else if (addr < PrioEnd) begin
          cmd_o.idx = addr[11:2];
          if (!wr) begin
            cmd_o.kind = K_PRIO_RD;
          end else if (addr[11:2] != 10'd0) begin
            cmd_o.kind = K_PRIO_WR;
          end
        end else if (addr >= PendBase && addr < PendEnd) begin
          cmd_o.idx = off_p[11:2];
          if (!wr) begin
            cmd_o.kind = K_PEND_RD;
          end
        end else if (addr >= EnBaseM && addr < EnEndM) begin
          cmd_o.idx  = off_m[11:2];
          cmd_o.kind = wr ? K_EN_WR : K_EN_RD;
        end else if (addr >= EnBaseS && addr < EnEndS) begin
          cmd_o.idx  = off_s[11:2];
          cmd_o.ctx  = CtxS;
          cmd_o.kind = wr ? K_EN_WR : K_EN_RD;
        end else if (addr == ThrM || addr == ThrS) begin
          cmd_o.ctx  = (addr == ThrS) ? CtxS : CtxM;
          cmd_o.kind = wr ? K_THR_WR : K_THR_RD;
        end else if (addr == ClmM || addr == ClmS) begin
          cmd_o.ctx = (addr == ClmS) ? CtxS : CtxM;
          cmd_o.idx = req_i.data.wdata[9:0];
          if (!wr) begin
            cmd_o.kind = K_CLAIM;
          end else if (cid_ok) begin
            cmd_o.kind = K_COMPLETE;
          end
        end
      end
      FuncLine: begin
        cmd_o.idx = req_i.data.line_id;
        if (lid_ok) begin
          cmd_o.kind = K_LINE;
        end
      end
      default: begin
        cmd_o.kind = K_NONE;
      end
    endcase
  end
endmodule

>>> rtl/core/plic_fifo.sv
module plic_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  plic_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            vld_o,
  output plic_pkg::cmd_t  cmd_o
);
  import plic_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o = (cnt_q == 2'd2);
  assign vld_o  = (cnt_q != 2'd0);
  assign cmd_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end
endmodule

>>> rtl/core/plic_back.sv
module plic_back #(
  parameter int NUM_SOURCES   = 63,
  parameter int PRIORITY_BITS = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  plic_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  plic_rsp_if.source      rsp_o
);
  import plic_pkg::*;

  localparam int NumWords = (NUM_SOURCES + 32) / 32;
  localparam int NumBits  = NumWords * 32;
  localparam int SrcW     = $clog2(NumBits);
  localparam int PaW      = $clog2(NUM_SOURCES + 1);
  localparam int WW       = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int PB       = PRIORITY_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_PRD,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_e;

  state_e                    state_q;
  cmd_t                      cmd_q;
  logic [NumBits-1:0]        pend_q;
  logic [NumBits-1:0]        clm_q;
  logic [1:0][NumBits-1:0]   en_q;
  logic [1:0][PB-1:0]        thr_q;
  logic [1:0][PaW-1:0]       cid_q;
  logic [NUM_SOURCES:0]      pvld_q;
  logic [31:0]               rdata_q;
  logic                      fault_q;
  logic                      rvld_q;
  logic [PaW-1:0]            scan_q;
  logic                      s1_vld_q;
  logic [PaW-1:0]            s1_src_q;
  logic                      s1_pv_q;
  logic [1:0][1:0]           cnt_q;
  logic [1:0][PaW-1:0]       first_q;
  logic [PaW-1:0]            best_q;
  logic [PB-1:0]             bp_q;
  logic                      out_vld_q;
  rsp_t                      out_q;

  logic                      ram_we;
  logic [PaW-1:0]            ram_addr;
  logic [PB-1:0]             ram_rdata;
  logic [PB-1:0]             prio_s1;
  logic [SrcW-1:0]           src_s1;
  logic [1:0]                elig;
  logic [SrcW-1:0]           cmd_src;
  logic [PaW-1:0]            cmd_pidx;
  logic [WW+4:0]             wbase;
  logic [31:0]               en_mask;
  logic                      out_free;
  logic [PaW-1:0]            best_eff;
  logic [1:0]                irq;
  logic                      claim_hit;

  plic_ram #(
    .WIDTH(PB),
    .DEPTH(NUM_SOURCES + 1)
  ) u_prio_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(cmd_q.wdata[PB-1:0]),
    .rdata_o(ram_rdata)
  );

  assign cmd_src  = cmd_q.idx[SrcW-1:0];
  assign cmd_pidx = cmd_q.idx[PaW-1:0];
  assign wbase    = {cmd_q.idx[WW-1:0], 5'd0};
  assign pop_o    = (state_q == S_IDLE) && vld_i;
  assign out_free = !out_vld_q || rsp_o.ready;

  // priority memory port: writes and single reads in APPLY, scan reads after
  assign ram_we   = (state_q == S_APPLY) && (cmd_q.kind == K_PRIO_WR);
  assign ram_addr = (state_q == S_SCAN) ? scan_q : cmd_pidx;

  // enable write mask: only sources 1..NUM_SOURCES exist
  always_comb begin
    for (int b = 0; b < 32; b++) begin
      en_mask[b] = ((32'(wbase) + 32'(b)) <= 32'(NUM_SOURCES)) &&
                   !(cmd_q.idx[WW-1:0] == '0 && b == 0);
    end
  end

  // eligibility of the source returned by the memory
  assign prio_s1 = s1_pv_q ? ram_rdata : '0;
  assign src_s1  = SrcW'(s1_src_q);
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      elig[c] = pend_q[src_s1] && en_q[c][src_s1] && !clm_q[src_s1] &&
                (prio_s1 > thr_q[c]);
    end
  end

  // irq after the item: the claimed source drops out of the count
  assign claim_hit = (cmd_q.kind == K_CLAIM) && (best_q != '0);
  assign best_eff  = (cmd_q.kind == K_CLAIM) ? best_q : '0;
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      irq[c] = (cnt_q[c] == 2'd2) || ((cnt_q[c] == 2'd1) && (first_q[c] != best_eff));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pend_q    <= '0;
      clm_q     <= '0;
      en_q      <= '0;
      thr_q     <= '0;
      cid_q     <= '0;
      pvld_q    <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      first_q   <= '0;
      best_q    <= '0;
      bp_q      <= '0;
      scan_q    <= '0;
      rvld_q    <= 1'b0;
      rdata_q   <= '0;
      fault_q   <= 1'b0;
      s1_src_q  <= '0;
      s1_pv_q   <= 1'b0;
      cmd_q     <= '0;
      out_q     <= '0;
    end else begin
      if (out_vld_q && rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end

      // scan evaluation stage
      if (s1_vld_q) begin
        for (int c = 0; c < 2; c++) begin
          if (elig[c]) begin
            if (cnt_q[c] == 2'd0) begin
              first_q[c] <= s1_src_q;
            end
            if (cnt_q[c] != 2'd2) begin
              cnt_q[c] <= cnt_q[c] + 2'd1;
            end
          end
        end
        if (elig[cmd_q.ctx] && prio_s1 > bp_q) begin
          bp_q   <= prio_s1;
          best_q <= s1_src_q;
        end
      end

      case (state_q)
        S_IDLE: begin
          if (vld_i) begin
            cmd_q   <= cmd_i;
            rdata_q <= '0;
            fault_q <= 1'b0;
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          case (cmd_q.kind)
            K_FAULT:   fault_q <= 1'b1;
            K_PRIO_WR: pvld_q[cmd_pidx] <= 1'b1;
            K_PRIO_RD: rvld_q <= pvld_q[cmd_pidx];
            K_PEND_RD: rdata_q <= pend_q[wbase +: 32];
            K_EN_RD:   rdata_q <= en_q[cmd_q.ctx][wbase +: 32];
            K_EN_WR:   en_q[cmd_q.ctx][wbase +: 32] <= cmd_q.wdata & en_mask;
            K_THR_RD:  rdata_q <= 32'(thr_q[cmd_q.ctx]);
            K_THR_WR:  thr_q[cmd_q.ctx] <= cmd_q.wdata[PB-1:0];
            K_COMPLETE: begin
              clm_q[cmd_src] <= 1'b0;
              if (!pend_q[cmd_src]) begin
                cid_q[cmd_q.ctx] <= '0;
              end
            end
            K_LINE: begin
              pend_q[cmd_src] <= cmd_q.level;
              if (!cmd_q.level) begin
                clm_q[cmd_src] <= 1'b0;
              end
            end
            default: ;
          endcase
          scan_q  <= PaW'(1);
          cnt_q   <= '0;
          first_q <= '0;
          best_q  <= '0;
          bp_q    <= '0;
          state_q <= (cmd_q.kind == K_PRIO_RD) ? S_PRD : S_SCAN;
        end
        S_PRD: begin
          rdata_q <= rvld_q ? 32'(ram_rdata) : 32'd0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          s1_vld_q <= 1'b1;
          s1_src_q <= scan_q;
          s1_pv_q  <= pvld_q[scan_q];
          scan_q   <= scan_q + PaW'(1);
          if (scan_q == PaW'(NUM_SOURCES)) begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          s1_vld_q <= 1'b0;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_vld_q     <= 1'b1;
            out_q.fault   <= fault_q;
            out_q.irq_m   <= irq[CtxM];
            out_q.irq_s   <= irq[CtxS];
            // claim returns the winner, or the last claim value when empty
            out_q.rdata   <= (cmd_q.kind != K_CLAIM) ? rdata_q :
                             claim_hit ? 32'(best_q) : 32'(cid_q[cmd_q.ctx]);
            if (claim_hit) begin
              clm_q[SrcW'(best_q)] <= 1'b1;
              cid_q[cmd_q.ctx]     <= best_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

`ifndef SYNTH
  a_src0_prio_unwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pvld_q[0]) else $error("priority of source 0 was written");

  a_en_bit0_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_q[0][0] && !en_q[1][0]) else $error("enable bit 0 set");

  a_done_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && out_free |=> (state_q == S_IDLE) && out_vld_q)
    else $error("finished transaction not delivered");
`endif
endmodule

>>> rtl/core/platform_interrupt_controller.sv
// Two-context platform interrupt controller (machine and supervisor).
// req_i carries one transaction per valid/ready handshake: a 32-bit bus
// read, a bus write or a change of one source line. rsp_o returns exactly
// one response per request, in order: read data, an access fault flag and
// both contexts' interrupt lines as they stand after the transaction.
// A two-entry command queue separates the address decoder from the
// execution unit, so requests are taken while earlier ones execute.
// Each transaction passes through the execution unit in steps: it is
// taken from the queue, the update is applied, a priority read also
// fetches its value from memory, every source is checked in turn through
// the single read port of the priority memory to find claim winners and
// the interrupt lines, the scan is drained and the response registered.
// The unit takes no new transaction until the last one's response is registered.
// Reset clears all priorities, pending, claimed, enable, threshold and
// claim state at once and empties the queue and the response register.
// If the receiver stalls, the response register holds its transaction,
// one more finished result waits in the execution unit, and the queue
// fills up before req_i.ready drops.
module platform_interrupt_controller #(
  parameter int NUM_SOURCES   = 63,
  parameter int PRIORITY_BITS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  plic_req_if.sink    req_i,
  plic_rsp_if.source  rsp_o
);
  import plic_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic cmd_vld;
  cmd_t cmd_in;
  cmd_t cmd_out;

  plic_front #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_front (
    .req_i (req_i),
    .full_i(full),
    .push_o(push),
    .cmd_o (cmd_in)
  );

  plic_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .cmd_i (cmd_in),
    .full_o(full),
    .pop_i (pop),
    .vld_o (cmd_vld),
    .cmd_o (cmd_out)
  );

  plic_back #(
    .NUM_SOURCES  (NUM_SOURCES),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (cmd_vld),
    .cmd_i (cmd_out),
    .pop_o (pop),
    .rsp_o (rsp_o)
  );
endmodule
